// ----- hw/rtl/ca_ring_cycle_finder_defines.svh -----
// assertion macros for the ring cycle finder
`ifndef CA_RING_CYCLE_FINDER_DEFINES_SVH
`define CA_RING_CYCLE_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define CRCF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crcf: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define CRCF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crcf: next-cycle check failed");
`else
`define CRCF_ASSERT_IMP(lbl, ante, cons)
`define CRCF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/crcf_pkg.sv -----
`default_nettype none

package crcf_pkg;

	localparam int MAX_RING    = 7;
	localparam int MIN_RING    = 3;
	localparam int RESET_LEN   = 4;
	localparam int LEN_W       = $clog2(MAX_RING + 1);
	localparam int IDX_W       = 2 * MAX_RING;
	localparam int CNT_W       = IDX_W + 1;
	localparam int STORE_DEPTH = 1 << IDX_W;
	localparam int NUM_SUMS    = 10;
	localparam int RULE_W      = 2 * NUM_SUMS;
	localparam int SUM_W       = 4;

	localparam logic OP_ANALYZE = 1'b0;
	localparam logic OP_FETCH   = 1'b1;

	typedef enum logic [1:0] {
		KIND_ANALYZED = 2'd0,
		KIND_LINK     = 2'd1,
		KIND_NONE     = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAP,
		S_MARK,
		S_REMOVE,
		S_SCAN,
		S_SCHK,
		S_LRD,
		S_LGET,
		S_LCHK
	} state_t;

	// one write address shared by the three arrays, one read address likewise
	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic [IDX_W-1:0] waddr;
		logic             succ_we;
		logic [IDX_W-1:0] succ_wd;
		logic             dead_we;
		logic             dead_wd;
		logic             flag_we;
		logic             flag_wd;
	} store_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] succ;
		logic             dead;
		logic             flag;
	} store_rd_t;

	// next cell value for a neighbourhood sum, zero beyond the table
	function automatic logic [1:0] rule_entry(input logic [RULE_W-1:0] rule,
			input logic [SUM_W-1:0] s);
		logic [1:0] r;
		r = 2'b00;
		for (int i = 0; i < NUM_SUMS; i++) begin
			if (s == SUM_W'(i)) begin
				r = rule[2*i +: 2];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crcf_next.sv -----
`default_nettype none

module crcf_next import crcf_pkg::*; (
	input  wire logic [IDX_W-1:0]  cfg,
	input  wire logic [LEN_W-1:0]  len,
	input  wire logic [RULE_W-1:0] rule,
	output logic      [IDX_W-1:0]  succ
);

	logic [1:0] dig [MAX_RING];
	logic [1:0] top;

	// most significant digit in use, i.e. cell len-1, the wrap neighbour of cell 0
	always_comb begin
		top = 2'b00;
		for (int k = 0; k < MAX_RING; k++) begin
			if (LEN_W'(k) == len - LEN_W'(1)) begin
				top = dig[k];
			end
		end
	end

	genvar k;
	for (k = 0; k < MAX_RING; k++) begin : g_cell
		logic [1:0]       up;
		logic [1:0]       dn;
		logic [SUM_W-1:0] s;

		assign dig[k] = cfg[2*k +: 2];

		if (k == 0) begin : g_wrap_dn
			assign dn = top;
		end else begin : g_plain_dn
			assign dn = dig[k-1];
		end

		if (k == MAX_RING - 1) begin : g_wrap_up
			assign up = dig[0];
		end else begin : g_plain_up
			assign up = (LEN_W'(k + 1) == len) ? dig[0] : dig[k+1];
		end

		assign s = SUM_W'(up) + SUM_W'(dig[k]) + SUM_W'(dn);
		assign succ[2*k +: 2] = (LEN_W'(k) < len) ? rule_entry(rule, s) : 2'b00;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/crcf_store.sv -----
`default_nettype none

module crcf_store import crcf_pkg::*; (
	input  wire logic       clk,
	input  wire store_cmd_t cmd,
	output store_rd_t       rd
);

	logic [IDX_W-1:0] succ_mem [STORE_DEPTH];
	logic             dead_mem [STORE_DEPTH];
	logic             flag_mem [STORE_DEPTH];
	store_rd_t        rd_q;

	always_ff @(posedge clk) begin
		if (cmd.succ_we) begin
			succ_mem[cmd.waddr] <= cmd.succ_wd;
		end
		if (cmd.dead_we) begin
			dead_mem[cmd.waddr] <= cmd.dead_wd;
		end
		if (cmd.flag_we) begin
			flag_mem[cmd.waddr] <= cmd.flag_wd;
		end
		rd_q.succ <= succ_mem[cmd.rd_addr];
		rd_q.dead <= dead_mem[cmd.rd_addr];
		rd_q.flag <= flag_mem[cmd.rd_addr];
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ca_ring_cycle_finder.sv -----
// analyze: maps all 4^L states, L the ring length, then R pruning rounds (R >= 1) of mark and
// remove passes; fetch: follows the open cycle, else scans past removed entries for a new one,
// or reports none left; one word at a time, result strobed in the cycle after the work ends
// each pass: at most one read and one write per cycle on a single-write, single-read array set
// reset clears control state and the rule register; the successor store is not cleared
// results cannot be held off: done lasts exactly one cycle
`default_nettype none
`include "ca_ring_cycle_finder_defines.svh"

module ca_ring_cycle_finder import crcf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [LEN_W-1:0]  ring_length,
	input  wire logic              cfg_we,
	input  wire logic [RULE_W-1:0] cfg_data,
	output logic                   done,
	output logic      [1:0]        result_kind,
	output logic      [IDX_W-1:0]  from_state,
	output logic      [IDX_W-1:0]  to_state,
	output logic                   cycle_end
);

	// sequencer and control registers
	state_t            state_q, state_d;
	logic [RULE_W-1:0] rule_q;
	logic [LEN_W-1:0]  len_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;       // sweep position for map, mark and remove passes
	logic              p_s1;        // a store read is in flight to the second step
	logic              removed_q;   // the current remove pass took something out
	logic [CNT_W-1:0]  cursor_q;    // scan position for new cycles
	logic [IDX_W-1:0]  chain_q;
	logic              in_chain_q;

	// payload registers
	logic [IDX_W-1:0]  addr_s1;
	logic [IDX_W-1:0]  node_q;      // tail of the link being reported
	logic [IDX_W-1:0]  link_to_q;   // its successor

	// result word
	logic              done_q;
	kind_t             kind_q;
	logic [IDX_W-1:0]  from_q;
	logic [IDX_W-1:0]  to_q;
	logic              end_q;

	// shared units
	store_cmd_t        store_cmd;
	store_rd_t         store_rd;
	logic [IDX_W-1:0]  next_cfg;

	logic              accept;
	logic              sweep_end;
	logic              last_map;
	logic              closes;
	logic [LEN_W-1:0]  len_clamp;
	logic [CNT_W-1:0]  chain_ext;

	logic              emit;
	kind_t             emit_kind;
	logic [IDX_W-1:0]  emit_from;
	logic [IDX_W-1:0]  emit_to;
	logic              emit_end;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign sweep_end = (idx_q == count_q);
	assign last_map  = (idx_q == count_q - CNT_W'(1));
	// link closes when the successor is already taken, itself included
	assign closes    = (link_to_q == node_q) || store_rd.dead;
	assign chain_ext = {1'b0, chain_q};

	// short rings are taken as the shortest legal ring, long ones as the longest
	always_comb begin
		len_clamp = ring_length;
		if (ring_length < LEN_W'(MIN_RING)) begin
			len_clamp = LEN_W'(MIN_RING);
		end else if (ring_length > LEN_W'(MAX_RING)) begin
			len_clamp = LEN_W'(MAX_RING);
		end
	end

	// next configuration of the one being mapped, one per cycle
	crcf_next u_next (
		.cfg  (idx_q[IDX_W-1:0]),
		.len  (len_q),
		.rule (rule_q),
		.succ (next_cfg)
	);

	// successor, removed and unreached arrays
	crcf_store u_store (
		.clk (clk),
		.cmd (store_cmd),
		.rd  (store_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (opcode == OP_ANALYZE) begin
						state_d = S_MAP;
					end else if (in_chain_q) begin
						state_d = S_LRD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_MAP: begin
				if (last_map) begin
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				if (sweep_end && !p_s1) begin
					state_d = S_REMOVE;
				end
			end
			S_REMOVE: begin
				if (sweep_end && !p_s1) begin
					state_d = removed_q ? S_MARK : S_IDLE;
				end
			end
			S_SCAN: begin
				state_d = (cursor_q >= count_q) ? S_IDLE : S_SCHK;
			end
			S_SCHK: begin
				state_d = store_rd.dead ? S_SCAN : S_LRD;
			end
			S_LRD: begin
				state_d = S_LGET;
			end
			S_LGET: begin
				state_d = S_LCHK;
			end
			S_LCHK: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// store commands and result word
	always_comb begin
		store_cmd         = '0;
		store_cmd.rd_addr = idx_q[IDX_W-1:0];
		store_cmd.waddr   = idx_q[IDX_W-1:0];
		store_cmd.succ_wd = next_cfg;
		emit              = 1'b0;
		emit_kind         = KIND_ANALYZED;
		emit_from         = '0;
		emit_to           = '0;
		emit_end          = 1'b0;
		case (state_q)
			S_MAP: begin
				// fresh entry: live and not yet reached
				store_cmd.succ_we = 1'b1;
				store_cmd.dead_we = 1'b1;
				store_cmd.dead_wd = 1'b0;
				store_cmd.flag_we = 1'b1;
				store_cmd.flag_wd = 1'b1;
			end
			S_MARK: begin
				// a live entry marks its successor as reached
				if (p_s1 && !store_rd.dead) begin
					store_cmd.waddr   = store_rd.succ;
					store_cmd.flag_we = 1'b1;
					store_cmd.flag_wd = 1'b0;
				end
			end
			S_REMOVE: begin
				// unreached live entries go; the flag is rearmed for the next round
				if (p_s1) begin
					store_cmd.waddr   = addr_s1;
					store_cmd.flag_we = 1'b1;
					store_cmd.flag_wd = 1'b1;
					if (store_rd.flag && !store_rd.dead) begin
						store_cmd.dead_we = 1'b1;
						store_cmd.dead_wd = 1'b1;
					end
				end
				if (sweep_end && !p_s1 && !removed_q) begin
					emit      = 1'b1;
					emit_kind = KIND_ANALYZED;
				end
			end
			S_SCAN: begin
				store_cmd.rd_addr = cursor_q[IDX_W-1:0];
				if (cursor_q >= count_q) begin
					emit      = 1'b1;
					emit_kind = KIND_NONE;
				end
			end
			S_LRD: begin
				store_cmd.rd_addr = node_q;
			end
			S_LGET: begin
				// retire the tail and look up whether the successor is still open
				store_cmd.waddr   = node_q;
				store_cmd.dead_we = 1'b1;
				store_cmd.dead_wd = 1'b1;
				store_cmd.rd_addr = store_rd.succ;
			end
			S_LCHK: begin
				emit      = 1'b1;
				emit_kind = KIND_LINK;
				emit_from = node_q;
				emit_to   = link_to_q;
				emit_end  = closes;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q     <= '0;
			len_q      <= LEN_W'(RESET_LEN);
			count_q    <= CNT_W'(1) << (2 * RESET_LEN);
			idx_q      <= '0;
			p_s1       <= 1'b0;
			removed_q  <= 1'b0;
			cursor_q   <= '0;
			chain_q    <= '0;
			in_chain_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= emit;
			if (cfg_we) begin
				rule_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_ANALYZE)) begin
						len_q      <= len_clamp;
						count_q    <= CNT_W'(1) << {len_clamp, 1'b0};
						idx_q      <= '0;
						p_s1       <= 1'b0;
						removed_q  <= 1'b0;
						cursor_q   <= '0;
						chain_q    <= '0;
						in_chain_q <= 1'b0;
					end
				end
				S_MAP: begin
					idx_q <= last_map ? '0 : idx_q + CNT_W'(1);
				end
				S_MARK, S_REMOVE: begin
					if (!sweep_end) begin
						idx_q <= idx_q + CNT_W'(1);
						p_s1  <= 1'b1;
					end else begin
						p_s1 <= 1'b0;
						if (!p_s1) begin
							idx_q <= '0;
							if (state_q == S_REMOVE) begin
								removed_q <= 1'b0;
							end
						end
					end
					if ((state_q == S_REMOVE) && p_s1 && store_rd.flag && !store_rd.dead) begin
						removed_q <= 1'b1;
					end
				end
				S_SCHK: begin
					cursor_q <= cursor_q + CNT_W'(1);
				end
				S_LCHK: begin
					in_chain_q <= !closes;
					chain_q    <= closes ? '0 : link_to_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q[IDX_W-1:0];
		if (accept && (opcode == OP_FETCH)) begin
			node_q <= chain_q;
		end
		if ((state_q == S_SCHK) && !store_rd.dead) begin
			node_q <= cursor_q[IDX_W-1:0];
		end
		if (state_q == S_LGET) begin
			link_to_q <= store_rd.succ;
		end
		if (emit) begin
			kind_q <= emit_kind;
			from_q <= emit_from;
			to_q   <= emit_to;
			end_q  <= emit_end;
		end
	end

	assign done        = done_q;
	assign result_kind = kind_q;
	assign from_state  = from_q;
	assign to_state    = to_q;
	assign cycle_end   = end_q;

	// a result only appears once the sequencer is back at rest
	`CRCF_ASSERT_IMP(a_done_idle, done, !busy)
	// an accepted word always starts work
	`CRCF_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// a chain being followed stays inside the analysed ring
	`CRCF_ASSERT_IMP(a_chain_range, in_chain_q, chain_ext < count_q)

endmodule

`default_nettype wire

// ----- test/ca_ring_cycle_finder_check.sv -----
module ca_ring_cycle_finder_check import crcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              opcode,
	input  logic [LEN_W-1:0]  ring_length,
	input  logic              cfg_we,
	input  logic [RULE_W-1:0] cfg_data,
	input  logic              done,
	input  logic [1:0]        result_kind,
	input  logic [IDX_W-1:0]  from_state,
	input  logic [IDX_W-1:0]  to_state,
	input  logic              cycle_end,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] tail;
		logic [IDX_W-1:0] head;
		logic             closes;
	} finder_word_t;

	finder_word_t      expected_words[$];
	logic [RULE_W-1:0] rule_reg;
	int unsigned       live_len;
	int unsigned       scan_pos;
	logic [IDX_W-1:0]  chain_at;
	logic              following;
	logic [IDX_W-1:0]  succ_of [STORE_DEPTH];
	bit                alive [STORE_DEPTH];
	bit                reached [STORE_DEPTH];

	// next cell for a neighbourhood sum, zero past the table
	function automatic logic [1:0] cell_rule(logic [RULE_W-1:0] rule, int unsigned s);
		if (s >= NUM_SUMS) begin
			return 2'd0;
		end
		return rule[2*s +: 2];
	endfunction

	function automatic logic [IDX_W-1:0] step_config(int unsigned cfgv, int unsigned len,
			logic [RULE_W-1:0] rule);
		int unsigned      digit [MAX_RING];
		logic [IDX_W-1:0] nxt;
		nxt = '0;
		for (int unsigned i = 0; i < len; i++) begin
			digit[i] = (cfgv >> (2 * (len - 1 - i))) & 3;
		end
		for (int unsigned i = 0; i < len; i++) begin
			nxt = {nxt[IDX_W-3:0],
				cell_rule(rule, digit[(i + len - 1) % len] + digit[i] + digit[(i + 1) % len])};
		end
		return nxt;
	endfunction

	// successor map, then strip configurations nothing leads to until only cycles remain
	task automatic build_cycles(int unsigned len_in);
		int unsigned len;
		int unsigned count;
		bit          removed;
		len = len_in;
		if (len < MIN_RING) begin
			len = MIN_RING;
		end
		if (len > MAX_RING) begin
			len = MAX_RING;
		end
		live_len = len;
		count = 1 << (2 * len);
		for (int unsigned j = 0; j < count; j++) begin
			succ_of[j] = step_config(j, len, rule_reg);
			alive[j] = 1'b1;
		end
		do begin
			removed = 1'b0;
			for (int unsigned j = 0; j < count; j++) begin
				reached[j] = 1'b0;
			end
			for (int unsigned j = 0; j < count; j++) begin
				if (alive[j]) begin
					reached[succ_of[j]] = 1'b1;
				end
			end
			for (int unsigned j = 0; j < count; j++) begin
				if (alive[j] && !reached[j]) begin
					alive[j] = 1'b0;
					removed = 1'b1;
				end
			end
		end while (removed);
		scan_pos = 0;
		chain_at = '0;
		following = 1'b0;
	endtask

	task automatic fetch_link(output finder_word_t w);
		int unsigned count;
		int unsigned tail;
		int unsigned head;
		w = '0;
		w.kind = KIND_NONE;
		if (following) begin
			tail = 32'(chain_at);
		end else begin
			count = 1 << (2 * live_len);
			while (scan_pos < count && !alive[scan_pos]) begin
				scan_pos++;
			end
			if (scan_pos >= count) begin
				return;
			end
			tail = scan_pos;
			scan_pos++;
		end
		head = 32'(succ_of[tail]);
		alive[tail] = 1'b0;
		// a reported or removed successor closes the cycle
		if (!alive[head]) begin
			following = 1'b0;
			chain_at = '0;
			w.closes = 1'b1;
		end else begin
			following = 1'b1;
			chain_at = IDX_W'(head);
		end
		w.kind = KIND_LINK;
		w.tail = IDX_W'(tail);
		w.head = IDX_W'(head);
	endtask

	always @(posedge clk or negedge arst_n) begin
		finder_word_t want;
		if (!arst_n) begin
			rule_reg = '0;
			live_len = RESET_LEN;
			scan_pos = 0;
			chain_at = '0;
			following = 1'b0;
			expected_words.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				rule_reg = cfg_data;
			end
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("unexpected result word, result_kind %0d", result_kind);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (result_kind !== want.kind) begin
						$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
						mismatches++;
					end
					if (from_state !== want.tail) begin
						$error("from_state: expected %0h, got %0h", want.tail, from_state);
						mismatches++;
					end
					if (to_state !== want.head) begin
						$error("to_state: expected %0h, got %0h", want.head, to_state);
						mismatches++;
					end
					if (cycle_end !== want.closes) begin
						$error("cycle_end: expected %0b, got %0b", want.closes, cycle_end);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				if (opcode == OP_ANALYZE) begin
					build_cycles(32'(ring_length));
					want = '0;
					want.kind = KIND_ANALYZED;
				end else begin
					fetch_link(want);
				end
				expected_words.push_back(want);
			end
			outstanding = expected_words.size();
		end
	end

endmodule

// ----- test/ca_ring_cycle_finder_test.sv -----
module ca_ring_cycle_finder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import crcf_pkg::*;

	localparam int unsigned RANDOM_WORDS = 80;
	// no idling over the last stretch of the random part
	localparam int unsigned CALM_TAIL    = 20;
	localparam int unsigned MAX_FETCHES  = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              opcode = OP_ANALYZE;
	logic [LEN_W-1:0]  ring_length = '0;
	logic              cfg_we = 1'b0;
	logic [RULE_W-1:0] cfg_data = '0;
	logic              busy;
	logic              done;
	logic [1:0]        result_kind;
	logic [IDX_W-1:0]  from_state;
	logic [IDX_W-1:0]  to_state;
	logic              cycle_end;
	int                mismatches;
	int                outstanding;

	int unsigned       random_sent = 0;
	bit                wide_done = 1'b0;

	// 100 MHz
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ca_ring_cycle_finder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.ring_length (ring_length),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.done        (done),
		.result_kind (result_kind),
		.from_state  (from_state),
		.to_state    (to_state),
		.cycle_end   (cycle_end)
	);

	ca_ring_cycle_finder_check watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.ring_length (ring_length),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.done        (done),
		.result_kind (result_kind),
		.from_state  (from_state),
		.to_state    (to_state),
		.cycle_end   (cycle_end),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// present one word from the falling edge and hold it until the block takes it;
	// start stays high so back-to-back words need no extra assignment
	task automatic send_word(logic op, logic [LEN_W-1:0] len);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		ring_length <= len;
		do @(posedge clk); while (busy);
	endtask

	// a fetch carries a junk length, which the block must ignore
	task automatic send_fetch();
		send_word(OP_FETCH, LEN_W'($urandom_range(0, 7)));
	endtask

	task automatic pause(int unsigned n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// random idle burst now and then, none in the calm tail
	task automatic maybe_pause();
		if (random_sent < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
			pause($urandom_range(1, 12));
		end
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// rule changes only with the block idle
	task automatic write_rule(logic [RULE_W-1:0] rule);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= rule;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small rings; a length of six at most once since it is slow
	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r < 7) begin
			return LEN_W'(3);
		end
		if (r < 10) begin
			return LEN_W'(4);
		end
		if (r < 12) begin
			return LEN_W'(5);
		end
		if (r < 15) begin
			// below the minimum, clamped to three
			return LEN_W'($urandom_range(0, 2));
		end
		if (!wide_done) begin
			wide_done = 1'b1;
			return LEN_W'(6);
		end
		return LEN_W'(4);
	endfunction

	function automatic logic [RULE_W-1:0] pick_rule();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return RULE_W'($urandom);
			end
		endcase
	endfunction

	initial begin
		int unsigned fetches;
		bit          pressed;
		pressed = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// rule of all zeros: everything falls onto the all-zero ring, a one-link cycle;
		// length zero is clamped up to three
		write_rule('0);
		send_word(OP_ANALYZE, LEN_W'(0));
		send_fetch();
		send_fetch();
		// exhausted, and stays so
		send_fetch();

		// rule of all threes on the longest ring: the only survivor is the all-three
		// configuration, reached after skipping every removed entry
		write_rule('1);
		send_word(OP_ANALYZE, LEN_W'(7));
		send_fetch();
		send_fetch();

		// next cell is the sum mod four: longer cycles to follow round
		write_rule(RULE_W'(20'h4E4E4));
		send_word(OP_ANALYZE, LEN_W'(5));
		repeat (6) begin
			maybe_pause();
			send_fetch();
		end
		// a fresh analysis part-way through a scan restarts it
		send_word(OP_ANALYZE, LEN_W'(2));
		repeat (3) begin
			send_fetch();
		end

		// random phases: a rule, an analysis, then a run of fetches that often exhausts
		while (random_sent < RANDOM_WORDS) begin
			if (random_sent == 0 ||
					(random_sent < RANDOM_WORDS - CALM_TAIL && $urandom_range(0, 2) == 0)) begin
				write_rule(pick_rule());
			end
			maybe_pause();
			send_word(OP_ANALYZE, pick_length());
			random_sent++;
			fetches = $urandom_range(0, MAX_FETCHES);
			repeat (fetches) begin
				maybe_pause();
				if ($urandom_range(0, 24) == 0) begin
					send_word(OP_ANALYZE, LEN_W'($urandom_range(3, 4)));
				end else begin
					send_fetch();
				end
				random_sent++;
			end
			// hold off once mid-run until the pipeline is empty
			if (!pressed && random_sent >= RANDOM_WORDS / 2) begin
				drain();
				pressed = 1'b1;
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#200_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/crcf_pkg.sv
hw/rtl/crcf_next.sv
hw/rtl/crcf_store.sv
hw/rtl/ca_ring_cycle_finder.sv
test/ca_ring_cycle_finder_check.sv
test/ca_ring_cycle_finder_test.sv
